/* rtl/core/frb_pkg.sv */
// Shared types and constants for the frame ring bin transpose.
package frb_pkg;

    localparam int WORD_W    = 32;
    localparam int CFG_W     = 4;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int BIN_W     = 3;
    localparam int POS_W     = 3;
    localparam int COUNT_W   = 4;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd15;

    // register index codes, taken from paddr[3:2]
    localparam logic [1:0] REG_RING_DEPTH     = 2'd0;
    localparam logic [1:0] REG_FEATURE_LENGTH = 2'd1;
    localparam logic [1:0] REG_SPEW_MODE      = 2'd2;

    // item function codes
    localparam logic FUNC_ELEMENT = 1'b0;
    localparam logic FUNC_CLEAR   = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    // effective settings and the store clear strobe from the register block
    typedef struct packed {
        logic [CFG_W-1:0] ring_depth;
        logic [CFG_W-1:0] feature_length;
        logic             spew_mode;
        logic             clear;
    } t_cfg;

endpackage

/* rtl/core/frb_if.sv */
// Item channels: input element items and output result items.
interface frb_in_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [frb_pkg::WORD_W-1:0] sample;
    logic                      last_element;

    modport source (output valid, output func, output sample, output last_element,
                    input ready);
    modport sink   (input valid, input func, input sample, input last_element,
                    output ready);
endinterface

interface frb_out_if;
    logic                      valid;
    logic                      ready;
    logic [frb_pkg::WORD_W-1:0] value;
    logic [frb_pkg::BIN_W-1:0]  bin_index;
    logic [frb_pkg::POS_W-1:0]  frame_position;
    logic                      last;

    modport source (output valid, output value, output bin_index, output frame_position,
                    output last, input ready);
    modport sink   (input valid, input value, input bin_index, input frame_position,
                    input last, output ready);
endinterface

/* rtl/core/frb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module frb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/frb_cfg.sv */
// APB register block: raw registers, clamped settings and store clear strobe.
module frb_cfg #(
    parameter int MAX_FRAMES = 8,
    parameter int MAX_LENGTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [frb_pkg::PADDR_W-1:0] paddr,
    input  logic [frb_pkg::PDATA_W-1:0] pwdata,
    output logic [frb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output frb_pkg::t_cfg               o_cfg
);
    import frb_pkg::*;

    logic [CFG_W-1:0] r_ring_depth;
    logic [CFG_W-1:0] r_feature_length;
    logic             r_spew_mode;
    logic             wr;
    logic             clr;
    logic [1:0]       idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr     = psel & penable & pwrite;
    // the store clears on the same edge as the register write
    assign clr    = wr & ((idx == REG_RING_DEPTH) | (idx == REG_FEATURE_LENGTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_depth     <= CFG_W'(1);
            r_feature_length <= CFG_W'(1);
            r_spew_mode      <= 1'b0;
        end else begin
            if (wr) begin
                case (idx)
                    REG_RING_DEPTH:     r_ring_depth     <= pwdata[CFG_W-1:0];
                    REG_FEATURE_LENGTH: r_feature_length <= pwdata[CFG_W-1:0];
                    REG_SPEW_MODE:      r_spew_mode      <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (idx)
            REG_RING_DEPTH:     prdata = PDATA_W'(r_ring_depth);
            REG_FEATURE_LENGTH: prdata = PDATA_W'(r_feature_length);
            REG_SPEW_MODE:      prdata = PDATA_W'(r_spew_mode);
            default:            prdata = '0;
        endcase
    end

    // zero acts as one, anything above the maximum acts as the maximum
    always_comb begin
        if (r_ring_depth == '0)
            o_cfg.ring_depth = CFG_W'(1);
        else if (32'(r_ring_depth) > MAX_FRAMES)
            o_cfg.ring_depth = CFG_W'(MAX_FRAMES);
        else
            o_cfg.ring_depth = r_ring_depth;

        if (r_feature_length == '0)
            o_cfg.feature_length = CFG_W'(1);
        else if (32'(r_feature_length) > MAX_LENGTH)
            o_cfg.feature_length = CFG_W'(MAX_LENGTH);
        else
            o_cfg.feature_length = r_feature_length;

        o_cfg.spew_mode = r_spew_mode;
        o_cfg.clear     = clr;
    end
endmodule

/* rtl/core/frb_seq.sv */
// Sequencer: stages a vector, copies it into the frame RAM, then walks the store bin-major.
module frb_seq #(
    parameter int MAX_FRAMES = 8,
    parameter int MAX_LENGTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  frb_pkg::t_cfg i_cfg,
    frb_in_if.sink        i_item,
    frb_out_if.source     o_result
);
    import frb_pkg::*;

    localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int LW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int DEPTH = MAX_FRAMES * MAX_LENGTH;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COPY    = 2'd1;
    localparam logic [1:0] ST_EMIT_RD = 2'd2;
    localparam logic [1:0] ST_EMIT_LD = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [FW-1:0]        r_wf, n_wf;
    logic [FW-1:0]        r_start, n_start;
    logic [FW-1:0]        r_slot, n_slot;
    logic [FW-1:0]        r_pos, n_pos;
    logic [LW-1:0]        r_bin, n_bin;
    logic [MAX_FRAMES-1:0] r_row_valid, n_row_valid;
    t_word                r_stage [MAX_LENGTH];

    logic                 r_ovalid, n_ovalid;
    t_word                r_ovalue;
    logic [BIN_W-1:0]     r_obin;
    logic [POS_W-1:0]     r_opos;
    logic                 r_olast;

    logic                 in_acc, out_acc;
    logic [COUNT_W-1:0]   len;
    logic                 stage_we;
    logic                 bin_end, pos_end, slot_end, blk_last;
    logic [FW-1:0]        wf_inc;
    logic                 wf_full;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    t_word                ram_q;

    assign i_item.ready = (r_state == ST_IDLE);
    assign in_acc       = i_item.valid & i_item.ready;
    assign out_acc      = r_ovalid & o_result.ready;

    assign len      = (r_count == COUNT_SAT) ? COUNT_SAT : r_count + COUNT_W'(1);
    assign stage_we = in_acc & (i_item.func == FUNC_ELEMENT) & (32'(r_count) < MAX_LENGTH);

    assign bin_end  = (32'(r_bin) == 32'(i_cfg.feature_length) - 1);
    assign pos_end  = (32'(r_pos) == 32'(i_cfg.ring_depth) - 1);
    assign slot_end = (32'(r_slot) == 32'(i_cfg.ring_depth) - 1);
    assign blk_last = bin_end & pos_end;
    assign wf_inc   = r_wf + FW'(1);
    assign wf_full  = (32'(r_wf) + 1 == 32'(i_cfg.ring_depth));

    // row address: slot * MAX_LENGTH + bin
    assign ram_we    = (r_state == ST_COPY);
    assign ram_waddr = AW'(32'(r_wf) * MAX_LENGTH + 32'(r_bin));
    assign ram_raddr = AW'(32'(r_slot) * MAX_LENGTH + 32'(r_bin));

    frb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_stage[r_bin]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (stage_we) begin
            r_stage[LW'(r_count)] <= i_item.sample;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_wf        = r_wf;
        n_start     = r_start;
        n_slot      = r_slot;
        n_pos       = r_pos;
        n_bin       = r_bin;
        n_row_valid = r_row_valid;
        n_ovalid    = r_ovalid & ~out_acc;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_item.func == FUNC_CLEAR) begin
                        n_count     = '0;
                        n_wf        = '0;
                        n_row_valid = '0;
                    end else if (!i_item.last_element) begin
                        n_count = len;
                    end else begin
                        n_count = '0;
                        if (len == i_cfg.feature_length) begin
                            n_bin   = '0;
                            n_state = ST_COPY;
                        end
                    end
                end
            end
            ST_COPY: begin
                n_bin = r_bin + LW'(1);
                if (bin_end) begin
                    n_row_valid[r_wf] = 1'b1;
                    n_wf    = wf_full ? '0 : wf_inc;
                    n_start = wf_full ? '0 : wf_inc;
                    n_slot  = wf_full ? '0 : wf_inc;
                    n_pos   = '0;
                    n_bin   = '0;
                    n_state = (wf_full || i_cfg.spew_mode) ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                // read is in flight; go on once the output register is free
                if (!r_ovalid || o_result.ready) begin
                    n_state = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                n_ovalid = 1'b1;
                if (pos_end) begin
                    n_pos  = '0;
                    n_slot = r_start;
                    n_bin  = r_bin + LW'(1);
                end else begin
                    n_pos  = r_pos + FW'(1);
                    n_slot = slot_end ? '0 : r_slot + FW'(1);
                end
                n_state = blk_last ? ST_IDLE : ST_EMIT_RD;
            end
            default: n_state = ST_IDLE;
        endcase

        if (i_cfg.clear) begin
            n_count     = '0;
            n_wf        = '0;
            n_row_valid = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_wf        <= '0;
            r_start     <= '0;
            r_slot      <= '0;
            r_pos       <= '0;
            r_bin       <= '0;
            r_row_valid <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wf        <= n_wf;
            r_start     <= n_start;
            r_slot      <= n_slot;
            r_pos       <= n_pos;
            r_bin       <= n_bin;
            r_row_valid <= n_row_valid;
            r_ovalid    <= n_ovalid;
        end
    end

    // unwritten frame rows read as zero
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT_LD) begin
            r_ovalue <= r_row_valid[r_slot] ? ram_q : '0;
            r_obin   <= BIN_W'(r_bin);
            r_opos   <= POS_W'(r_pos);
            r_olast  <= blk_last;
        end
    end

    assign o_result.valid          = r_ovalid;
    assign o_result.value          = r_ovalue;
    assign o_result.bin_index      = r_obin;
    assign o_result.frame_position = r_opos;
    assign o_result.last           = r_olast;
endmodule

/* rtl/core/frame_ring_bin_transpose.sv */
// Top level of the frame ring bin transpose (corner-turn store).
//
// Usage: element items enter on i_item (valid/ready), one 32-bit word each,
// with last_element on the final word of a vector; func = 1 clears the store.
// A vector of exactly feature_length words is copied into the next frame row
// of the ring. When the ring fills, or after every vector in spew mode, the
// store is read out on o_result bin-major, oldest frame first, with last set
// on the final word. Rows not written since the last clear read as zero.
// Flow: after the final item of a vector, the staged words are copied into the
// frame RAM bin by bin; a readout then takes each word through a RAM read and
// then an output register load. i_item.ready is low during copy and readout.
// A stalled receiver holds the output register; the readout waits on it.
// Reset empties the store at once (row valid flags), zeroes the ring pointer
// and loads ring_depth = 1, feature_length = 1, spew_mode = 0.
// Registers on APB: 0x0 ring_depth, 0x4 feature_length, 0x8 spew_mode; a write
// to either of the first two clears the store on the same edge.
module frame_ring_bin_transpose #(
    parameter int MAX_FRAMES = 8,
    parameter int MAX_LENGTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    frb_in_if.sink                      i_item,
    frb_out_if.source                   o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [frb_pkg::PADDR_W-1:0] paddr,
    input  logic [frb_pkg::PDATA_W-1:0] pwdata,
    output logic [frb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import frb_pkg::*;

    t_cfg cfg;

    frb_cfg #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    frb_seq #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (i_item),
        .o_result (o_result)
    );
endmodule
